// File: sv/asf_pkg.sv
// Shared constants and GF(2^8) helpers for the forward S-box.
// Used by asf_inv_pipe and aes_sbox_forward; depends on nothing.
package asf_pkg;

    localparam logic [8:0] GF_POLY  = 9'h11B;
    localparam logic [7:0] AFFINE_C = 8'h63;

    // GF(2^8) product, shift-and-add with reduction by GF_POLY
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = '0;
        p   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ p;
            end
            p = {p[6:0], 1'b0} ^ (p[7] ? GF_POLY[7:0] : 8'h00);
        end
        return acc;
    endfunction

    // squaring is linear over GF(2): synthesis folds this to an XOR network
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_mul(a, a);
    endfunction

    function automatic logic [7:0] affine(input logic [7:0] a);
        logic [7:0] b;
        b = a ^ {a[6:0], a[7]} ^ {a[5:0], a[7:6]} ^ {a[4:0], a[7:5]} ^ {a[3:0], a[7:4]};
        return b ^ AFFINE_C;
    endfunction

endpackage

// File: sv/asf_inv_pipe.sv
// Three-stage pipelined GF(2^8) inverse, computed as x^254.
// Depends on asf_pkg (gf_mul, gf_sq).
module asf_inv_pipe
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] inv_byte
);
    import asf_pkg::*;

    // x^254 = (x^2 * x^4) * (x^8 * x^16) * (x^32 * x^64) * x^128; zero maps to zero
    logic       s1_valid_reg;
    logic [7:0] s1_x6_reg, s1_x24_reg, s1_x96_reg, s1_x128_reg;
    logic       s2_valid_reg;
    logic [7:0] s2_x30_reg, s2_x224_reg;
    logic       s3_valid_reg;
    logic [7:0] s3_inv_reg;

    logic       s1_ready, s2_ready, s3_ready;
    logic [7:0] x2, x4, x8, x16, x32, x64, x128;

    // a stage takes a request when it is empty or its content moves on
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        x2   = gf_sq(in_byte);
        x4   = gf_sq(x2);
        x8   = gf_sq(x4);
        x16  = gf_sq(x8);
        x32  = gf_sq(x16);
        x64  = gf_sq(x32);
        x128 = gf_sq(x64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_x6_reg   <= gf_mul(x2, x4);
            s1_x24_reg  <= gf_mul(x8, x16);
            s1_x96_reg  <= gf_mul(x32, x64);
            s1_x128_reg <= x128;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_x30_reg  <= gf_mul(s1_x6_reg, s1_x24_reg);
            s2_x224_reg <= gf_mul(s1_x96_reg, s1_x128_reg);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_inv_reg <= gf_mul(s2_x30_reg, s2_x224_reg);
        end
    end

    assign out_valid = s3_valid_reg;
    assign inv_byte  = s3_inv_reg;

endmodule

// File: sv/aes_sbox_forward.sv
// AES forward S-box: pipelined field inverse followed by the affine map.
// Depends on asf_pkg and asf_inv_pipe.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  input   | in_valid, in_ready, in_byte     | in
//  output  | out_valid, out_ready,           | out
//          | sbox_byte, field_inverse        |
//
// One request per cycle sustained while out_ready is high; each byte passes three multiply
// stages of the x^254 chain, then the affine map into the output register.
// Reset clears only the stage valid bits. A stall on out_ready backs up
// stage by stage; bubbles are squeezed out, nothing is dropped or repeated.
module aes_sbox_forward
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] sbox_byte,
    output logic [7:0] field_inverse
);
    import asf_pkg::*;

    logic       inv_valid;
    logic       inv_ready;
    logic [7:0] inv_byte;
    logic       out_valid_reg;
    logic [7:0] sbox_reg, inv_reg;

    asf_inv_pipe u_inv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (inv_valid),
        .out_ready (inv_ready),
        .inv_byte  (inv_byte)
    );

    assign inv_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (inv_ready)
        begin
            out_valid_reg <= inv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (inv_ready && inv_valid)
        begin
            sbox_reg <= affine(inv_byte);
            inv_reg  <= inv_byte;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sbox_byte     = sbox_reg;
    assign field_inverse = inv_reg;

endmodule
